FILE: design/joystick_axis_conditioner_macros.svh
// Assertion helpers shared by the conditioner modules.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

// same-cycle implication
`define JAC_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jac: same-cycle check failed");

// next-cycle implication
`define JAC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jac: next-cycle check failed");

`endif

FILE: design/jac_pkg.sv
package jac_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int Q_W         = 7;                  // quotient never exceeds 100
    localparam int NUM_W       = SAMPLE_BITS + Q_W;  // holds deviation * 100
    localparam int STEP_W      = $clog2(Q_W);
    localparam int VAL_W       = 8;
    localparam int DIR_W       = 3;
    localparam int THR_W       = 7;
    localparam int ORIENT_W    = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = SAMPLE_BITS;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE     = '1;
    localparam logic [NUM_W-1:0]       SCALE_MAX_NUM  = NUM_W'(100);
    localparam logic signed [VAL_W-1:0] SCALE_MAX_VAL = VAL_W'(100);
    localparam logic [STEP_W-1:0]      DIV_FIRST_STEP = STEP_W'(Q_W - 1);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_X_CENTER  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_CENTER  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_X_DEADBND = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_DEADBND = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIENT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DIR_THR   = 3'd5;

    // reset values
    localparam logic [SAMPLE_BITS-1:0] RST_X_CENTER  = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] RST_Y_CENTER  = SAMPLE_BITS'(2048);
    localparam logic [SAMPLE_BITS-1:0] RST_X_DEADBND = SAMPLE_BITS'(50);
    localparam logic [SAMPLE_BITS-1:0] RST_Y_DEADBND = SAMPLE_BITS'(35);
    localparam logic [THR_W-1:0]       RST_DIR_THR   = THR_W'(40);

    // mounting rotation
    localparam logic [ORIENT_W-1:0] ORIENT_0   = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_90  = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_180 = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_270 = 2'd3;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    typedef struct packed {
        logic                   start;
        logic [NUM_W-1:0]       num;
        logic [SAMPLE_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_val;
        logic signed [VAL_W-1:0] y_val;
        logic [DIR_W-1:0]        dir;
    } t_orient_res;

endpackage

FILE: design/jac_divider.sv
`include "joystick_axis_conditioner_macros.svh"

// Restoring divider, one quotient bit per cycle, MSB first.
// Caller guarantees the quotient fits in Q_W bits.
module jac_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jac_pkg::t_div_req i_req,
    output jac_pkg::t_div_rsp o_rsp
);

    logic [jac_pkg::NUM_W-1:0]       r_rem, n_rem;
    logic [jac_pkg::SAMPLE_BITS-1:0] r_den, n_den;
    logic [jac_pkg::Q_W-1:0]         r_quot, n_quot;
    logic [jac_pkg::STEP_W-1:0]      r_step, n_step;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;

    logic [jac_pkg::NUM_W-1:0] den_sh;
    logic [jac_pkg::NUM_W:0]   diff;
    logic                      fits;

    assign den_sh = {{(jac_pkg::NUM_W - jac_pkg::SAMPLE_BITS){1'b0}}, r_den} << r_step;
    assign diff   = {1'b0, r_rem} - {1'b0, den_sh};
    assign fits   = ~diff[jac_pkg::NUM_W];

    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start && !r_busy) begin
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quot = '0;
            n_step = jac_pkg::DIV_FIRST_STEP;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = diff[jac_pkg::NUM_W-1:0];
            end
            n_quot = {r_quot[jac_pkg::Q_W-2:0], fits};
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
        r_step <= n_step;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    `JAC_CHECK_NEXT(a_start_busy, i_req.start && !r_busy, r_busy)
    `JAC_CHECK_NEXT(a_last_step_done, r_busy && (r_step == '0), r_done && !r_busy)

endmodule

FILE: design/jac_orient.sv
// Mounting rotation and direction pick (left, right, up, down), X before Y.
module jac_orient (
    input  logic signed [jac_pkg::VAL_W-1:0] i_sx,
    input  logic signed [jac_pkg::VAL_W-1:0] i_sy,
    input  logic [jac_pkg::ORIENT_W-1:0]     i_orient,
    input  logic [jac_pkg::THR_W-1:0]        i_thr,
    output jac_pkg::t_orient_res             o_res
);

    logic signed [jac_pkg::VAL_W-1:0] xv, yv;
    logic signed [jac_pkg::VAL_W:0]   x9, y9, thr9;

    always_comb begin
        case (i_orient)
            jac_pkg::ORIENT_90: begin
                xv = -i_sy;
                yv = i_sx;
            end
            jac_pkg::ORIENT_180: begin
                xv = -i_sx;
                yv = -i_sy;
            end
            jac_pkg::ORIENT_270: begin
                xv = i_sy;
                yv = -i_sx;
            end
            default: begin
                xv = i_sx;
                yv = i_sy;
            end
        endcase
    end

    assign x9   = {xv[jac_pkg::VAL_W-1], xv};
    assign y9   = {yv[jac_pkg::VAL_W-1], yv};
    assign thr9 = {{(jac_pkg::VAL_W + 1 - jac_pkg::THR_W){1'b0}}, i_thr};

    always_comb begin
        o_res.x_val = xv;
        o_res.y_val = yv;
        if (x9 < -thr9) begin
            o_res.dir = jac_pkg::DIR_LEFT;
        end else if (x9 > thr9) begin
            o_res.dir = jac_pkg::DIR_RIGHT;
        end else if (y9 > thr9) begin
            o_res.dir = jac_pkg::DIR_UP;
        end else if (y9 < -thr9) begin
            o_res.dir = jac_pkg::DIR_DOWN;
        end else begin
            o_res.dir = jac_pkg::DIR_NONE;
        end
    end

endmodule

FILE: design/joystick_axis_conditioner.sv
// Joystick axis conditioner. Takes one X/Y sample pair plus the active-low
// button level per item and returns one result: both axes dead-zoned and
// scaled to -100..100 around their configured centers, rotated by the
// mounting orientation, a press-edge flag and a direction, with X taking
// priority over Y. Both axes share one restoring divider that produces one
// quotient bit per cycle; an item passes through acceptance, then per axis a
// setup, the divide and a store, then the output load, and an axis inside
// its dead zone skips the divider. The input is not ready while an item is
// being worked on; a finished result sits in the output register until
// taken. Registers are written through the plain write port; the user must
// write them only while the block is idle; the block does not enforce it.
`include "joystick_axis_conditioner_macros.svh"

module joystick_axis_conditioner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [jac_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [jac_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [jac_pkg::SAMPLE_BITS-1:0]     i_raw_x,
    input  logic [jac_pkg::SAMPLE_BITS-1:0]     i_raw_y,
    input  logic                                i_button_level,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [jac_pkg::VAL_W-1:0]    o_x_value,
    output logic signed [jac_pkg::VAL_W-1:0]    o_y_value,
    output logic                                o_press_edge,
    output logic [jac_pkg::DIR_W-1:0]           o_stick_direction
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // configuration registers
    logic [jac_pkg::SAMPLE_BITS-1:0] r_x_center, r_y_center;
    logic [jac_pkg::SAMPLE_BITS-1:0] r_x_deadband, r_y_deadband;
    logic [jac_pkg::ORIENT_W-1:0]    r_orient;
    logic [jac_pkg::THR_W-1:0]       r_dir_thr;

    // sequencer and item state
    logic [1:0]                       r_state, n_state;
    logic                             r_axis, n_axis;
    logic                             r_last_btn, n_last_btn;
    logic [jac_pkg::SAMPLE_BITS-1:0]  r_raw_x, n_raw_x, r_raw_y, n_raw_y;
    logic                             r_edge, n_edge;
    logic                             r_above, n_above;
    logic signed [jac_pkg::VAL_W-1:0] r_sx, n_sx, r_sy, n_sy;

    // output register
    logic                             r_out_valid, n_out_valid;
    logic signed [jac_pkg::VAL_W-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic                             r_out_edge, n_out_edge;
    logic [jac_pkg::DIR_W-1:0]        r_out_dir, n_out_dir;

    // axis setup
    logic [jac_pkg::SAMPLE_BITS-1:0]  raw_sel, ctr_sel, band_sel, dev, mag;
    logic                             above, skip;
    logic signed [jac_pkg::VAL_W-1:0] q_ext, scaled;

    logic                             out_x_ok, out_y_ok;

    jac_pkg::t_div_req  div_req;
    jac_pkg::t_div_rsp  div_rsp;
    jac_pkg::t_orient_res orient_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center   <= jac_pkg::RST_X_CENTER;
            r_y_center   <= jac_pkg::RST_Y_CENTER;
            r_x_deadband <= jac_pkg::RST_X_DEADBND;
            r_y_deadband <= jac_pkg::RST_Y_DEADBND;
            r_orient     <= jac_pkg::ORIENT_0;
            r_dir_thr    <= jac_pkg::RST_DIR_THR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                jac_pkg::REG_X_CENTER:  r_x_center   <= i_cfg_wdata;
                jac_pkg::REG_Y_CENTER:  r_y_center   <= i_cfg_wdata;
                jac_pkg::REG_X_DEADBND: r_x_deadband <= i_cfg_wdata;
                jac_pkg::REG_Y_DEADBND: r_y_deadband <= i_cfg_wdata;
                jac_pkg::REG_ORIENT:    r_orient     <= i_cfg_wdata[jac_pkg::ORIENT_W-1:0];
                jac_pkg::REG_DIR_THR:   r_dir_thr    <= i_cfg_wdata[jac_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign raw_sel  = r_axis ? r_raw_y : r_raw_x;
    assign ctr_sel  = r_axis ? r_y_center : r_x_center;
    assign band_sel = r_axis ? r_y_deadband : r_x_deadband;
    assign above    = raw_sel > ctr_sel;
    assign dev      = above ? (raw_sel - ctr_sel) : (ctr_sel - raw_sel);
    // dead zone, or below-center branch with a zero center
    assign skip     = (dev < band_sel) || (!above && (ctr_sel == '0));
    assign mag      = above ? (raw_sel - ctr_sel) : raw_sel;

    assign div_req.start = (r_state == S_PREP) && !skip;
    assign div_req.num   = {{jac_pkg::Q_W{1'b0}}, mag} * jac_pkg::SCALE_MAX_NUM;
    assign div_req.den   = above ? (jac_pkg::FULL_SCALE - ctr_sel) : ctr_sel;

    jac_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign q_ext  = {{(jac_pkg::VAL_W - jac_pkg::Q_W){1'b0}}, div_rsp.quot};
    assign scaled = r_above ? q_ext : (q_ext - jac_pkg::SCALE_MAX_VAL);

    jac_orient u_orient (
        .i_sx     (r_sx),
        .i_sy     (r_sy),
        .i_orient (r_orient),
        .i_thr    (r_dir_thr),
        .o_res    (orient_res)
    );

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_last_btn  = r_last_btn;
        n_raw_x     = r_raw_x;
        n_raw_y     = r_raw_y;
        n_edge      = r_edge;
        n_above     = r_above;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_edge  = r_out_edge;
        n_out_dir   = r_out_dir;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw_x    = i_raw_x;
                    n_raw_y    = i_raw_y;
                    n_edge     = !i_button_level && r_last_btn;
                    n_last_btn = i_button_level;
                    n_axis     = 1'b0;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                n_above = above;
                if (skip) begin
                    if (r_axis) begin
                        n_sy    = '0;
                        n_state = S_DONE;
                    end else begin
                        n_sx   = '0;
                        n_axis = 1'b1;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_axis) begin
                        n_sy    = scaled;
                        n_state = S_DONE;
                    end else begin
                        n_sx    = scaled;
                        n_axis  = 1'b1;
                        n_state = S_PREP;
                    end
                end
            end
            S_DONE: begin
                // load only once the previous result is gone or leaving
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = orient_res.x_val;
                    n_out_y     = orient_res.y_val;
                    n_out_edge  = r_edge;
                    n_out_dir   = orient_res.dir;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_last_btn  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_last_btn  <= n_last_btn;
            r_out_valid <= n_out_valid;
        end
        r_raw_x    <= n_raw_x;
        r_raw_y    <= n_raw_y;
        r_edge     <= n_edge;
        r_above    <= n_above;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_edge <= n_out_edge;
        r_out_dir  <= n_out_dir;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_x_value         = r_out_x;
    assign o_y_value         = r_out_y;
    assign o_press_edge      = r_out_edge;
    assign o_stick_direction = r_out_dir;

    assign out_x_ok = (r_out_x >= -jac_pkg::SCALE_MAX_VAL) && (r_out_x <= jac_pkg::SCALE_MAX_VAL);
    assign out_y_ok = (r_out_y >= -jac_pkg::SCALE_MAX_VAL) && (r_out_y <= jac_pkg::SCALE_MAX_VAL);

    `JAC_CHECK_NEXT(a_accept_setup, i_in_valid && o_in_ready, r_state == S_PREP && !r_axis)
    `JAC_CHECK_NOW(a_div_active, r_state == S_DIV, div_rsp.busy || div_rsp.done)
    `JAC_CHECK_NOW(a_out_range, r_out_valid, out_x_ok && out_y_ok)

endmodule
